// ===== rtl/json_string_unescape_macros.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_macros.svh
// Assertion macros used by the port-level checker of the string unescaper.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu: same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define JSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu: next-cycle check failed");

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes shared by the string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CTRL     = 3'd1,
    ERR_UTF8     = 3'd2,
    ERR_ESCAPE   = 3'd3,
    ERR_HEX      = 3'd4,
    ERR_SURR     = 3'd5,
    ERR_END      = 3'd6
  } err_e;

  localparam int unsigned MaxRes = 4;

  // results caused by one input beat
  typedef struct packed {
    logic [2:0]             cnt;    // 0..MaxRes results
    logic [MaxRes-1:0][7:0] bytes;  // bytes[0] goes out first
    logic                   done;
    err_e                   err;
  } grp_t;

endpackage

// ===== rtl/jsu_ifs.sv =====
// ----------------------------------------------------------------------------
// jsu_ifs
// Valid/ready channel interfaces for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       input_end;

  modport source (output valid, data_byte, input_end, input ready);
  modport sink   (input valid, data_byte, input_end, output ready);
  modport mon    (input valid, ready, data_byte, input_end);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       string_done;
  logic [2:0] error_code;

  modport source (output valid, out_byte, byte_valid, last, string_done, error_code,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, string_done, error_code,
                  output ready);
  modport mon    (input valid, ready, out_byte, byte_valid, last, string_done,
                  error_code);
endinterface

// ===== rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Escape/UTF-8 state machine; builds the result group of one input beat.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          input_end_i,
  output jsu_pkg::grp_t grp_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL, M_CONT, M_ESC, M_HEX1, M_SURR_BS, M_SURR_U, M_HEX2
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [9:0]  hs_q, hs_d;
  logic [1:0]  cont_q, cont_d;

  logic [3:0]  nib;
  logic        nib_ok;
  logic [15:0] acc_n;
  logic [20:0] cp;
  grp_t        enc;

  // hex digit value
  always_comb begin
    nib    = data_byte_i[3:0];
    nib_ok = 1'b1;
    if (data_byte_i inside {[8'h30:8'h39]}) begin
      nib = data_byte_i[3:0];
    end else if (data_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = data_byte_i[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign acc_n = {acc_q[11:0], nib};
  assign cp    = (mode_q == M_HEX2) ? (21'({hs_q, acc_n[9:0]}) + 21'h01_0000)
                                    : {5'd0, acc_n};

  // code point to UTF-8
  always_comb begin
    enc = '0;
    if (cp <= 21'h7F) begin
      enc.cnt      = 3'd1;
      enc.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      enc.cnt      = 3'd2;
      enc.bytes[0] = {3'b110, cp[10:6]};
      enc.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      enc.cnt      = 3'd3;
      enc.bytes[0] = {4'b1110, cp[15:12]};
      enc.bytes[1] = {2'b10, cp[11:6]};
      enc.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc.cnt      = 3'd4;
      enc.bytes[0] = {5'b11110, cp[20:18]};
      enc.bytes[1] = {2'b10, cp[17:12]};
      enc.bytes[2] = {2'b10, cp[11:6]};
      enc.bytes[3] = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    logic       emit;
    logic [7:0] emit_b;
    logic       use_enc;
    logic       done;
    err_e       err;

    mode_d  = mode_q;
    acc_d   = acc_q;
    hcnt_d  = hcnt_q;
    hs_d    = hs_q;
    cont_d  = cont_q;
    emit    = 1'b0;
    emit_b  = data_byte_i;
    use_enc = 1'b0;
    done    = 1'b0;
    err     = ERR_NONE;
    grp_o   = '0;

    if (input_end_i) begin
      err = ERR_END;
    end else begin
      case (mode_q)
        M_CONT: begin
          if (!(data_byte_i inside {[8'h80:8'hBF]})) begin
            err = ERR_UTF8;
          end else begin
            cont_d = cont_q - 2'd1;
            if (cont_q == 2'd1) mode_d = M_NORMAL;
            emit = 1'b1;
          end
        end
        M_ESC: begin
          mode_d = M_NORMAL;
          case (data_byte_i)
            ChQuote, ChBslash, ChSlash: emit = 1'b1;
            ChB: begin emit = 1'b1; emit_b = 8'h08; end
            ChF: begin emit = 1'b1; emit_b = 8'h0C; end
            ChN: begin emit = 1'b1; emit_b = 8'h0A; end
            ChR: begin emit = 1'b1; emit_b = 8'h0D; end
            ChT: begin emit = 1'b1; emit_b = 8'h09; end
            ChU: begin
              mode_d = M_HEX1;
              acc_d  = '0;
              hcnt_d = '0;
            end
            default: err = ERR_ESCAPE;
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!nib_ok) begin
            err = ERR_HEX;
          end else begin
            acc_d = acc_n;
            if (hcnt_q != 2'd3) begin
              hcnt_d = hcnt_q + 2'd1;
            end else begin
              hcnt_d = '0;
              if (mode_q == M_HEX1) begin
                if (acc_n inside {[16'hD800:16'hDBFF]}) begin
                  hs_d   = acc_n[9:0];
                  mode_d = M_SURR_BS;
                end else if (acc_n inside {[16'hDC00:16'hDFFF]}) begin
                  err = ERR_SURR;
                end else begin
                  mode_d  = M_NORMAL;
                  use_enc = 1'b1;
                end
              end else if (!(acc_n inside {[16'hDC00:16'hDFFF]})) begin
                err = ERR_SURR;
              end else begin
                mode_d  = M_NORMAL;
                use_enc = 1'b1;
              end
            end
          end
        end
        M_SURR_BS: begin
          if (data_byte_i != ChBslash) err = ERR_SURR;
          else mode_d = M_SURR_U;
        end
        M_SURR_U: begin
          if (data_byte_i != ChU) begin
            err = ERR_SURR;
          end else begin
            mode_d = M_HEX2;
            acc_d  = '0;
            hcnt_d = '0;
          end
        end
        default: begin
          mode_d = M_NORMAL;
          if (data_byte_i == ChQuote) begin
            done = 1'b1;
          end else if (data_byte_i == ChBslash) begin
            mode_d = M_ESC;
          end else if (data_byte_i < 8'h20) begin
            err = ERR_CTRL;
          end else if (data_byte_i <= 8'h7F) begin
            emit = 1'b1;
          end else if (data_byte_i inside {[8'hC0:8'hDF]}) begin
            cont_d = 2'd1; mode_d = M_CONT; emit = 1'b1;
          end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
            cont_d = 2'd2; mode_d = M_CONT; emit = 1'b1;
          end else if (data_byte_i inside {[8'hF0:8'hF7]}) begin
            cont_d = 2'd3; mode_d = M_CONT; emit = 1'b1;
          end else begin
            err = ERR_UTF8;
          end
        end
      endcase
    end

    if (done || err != ERR_NONE) begin
      // string ends: one status result, state back to reset values
      mode_d    = M_NORMAL;
      acc_d     = '0;
      hcnt_d    = '0;
      hs_d      = '0;
      cont_d    = '0;
      grp_o.cnt  = 3'd1;
      grp_o.done = done;
      grp_o.err  = err;
    end else if (emit) begin
      grp_o.cnt      = 3'd1;
      grp_o.bytes[0] = emit_b;
    end else if (use_enc) begin
      grp_o = enc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      acc_q  <= '0;
      hcnt_q <= '0;
      hs_q   <= '0;
      cont_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      hcnt_q <= hcnt_d;
      hs_q   <= hs_d;
      cont_q <= cont_d;
    end
  end

endmodule

// ===== rtl/jsu_serialize.sv =====
// ----------------------------------------------------------------------------
// jsu_serialize
// Group register and output register; sends a group one result per beat.
// ----------------------------------------------------------------------------
module jsu_serialize (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          grp_wr_i,
  input  jsu_pkg::grp_t grp_i,
  output logic          grp_free_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          last_o,
  output logic          string_done_o,
  output logic [2:0]    error_code_o
);
  import jsu_pkg::*;

  grp_t       grp_q;
  logic       grp_v_q;
  logic [1:0] idx_q;
  logic       out_v_q;

  logic out_load, move, move_last, status;

  assign out_load   = !out_v_q || out_ready_i;
  assign move       = grp_v_q && out_load;
  assign move_last  = move && ({1'b0, idx_q} == (grp_q.cnt - 3'd1));
  assign grp_free_o = !grp_v_q || move_last;
  assign status     = grp_q.done || (grp_q.err != ERR_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (grp_wr_i) begin
        grp_v_q <= 1'b1;
        idx_q   <= '0;
      end else if (move_last) begin
        grp_v_q <= 1'b0;
      end else if (move) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_load) out_v_q <= move;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (grp_wr_i) grp_q <= grp_i;
    if (move) begin
      out_byte_o    <= grp_q.bytes[idx_q];
      byte_valid_o  <= !status;
      last_o        <= move_last;
      string_done_o <= grp_q.done;
      error_code_o  <= grp_q.err;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// ===== rtl/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body unescaper with UTF-8 output, one raw byte per input beat.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                          handshake
//   in_i     in   data_byte[7:0], input_end                        valid/ready
//   res_o    out  out_byte[7:0], byte_valid, last, string_done,    valid/ready
//                 error_code[2:0]
//
// Input: an input beat is taken every cycle while the group register is free
//   or sends its last result; a beat that causes n > 0 results (n up to 4)
//   keeps the group register until its last result moves on, so the input
//   stalls behind it.
// Path: a beat's results pass the group register, then the output register.
// Reset: clears decoder state and both valid flags; no clearing pass.
// Stalls: the output register keeps its result while res_o.ready is low; the
//   group register still takes one more beat's results behind it.
//
module json_string_unescape (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source res_o
);
  import jsu_pkg::*;

  grp_t grp;          // results of the beat on in_i, combinational
  logic in_accept;
  logic grp_free;

  assign in_i.ready = grp_free;
  assign in_accept  = in_i.valid && grp_free;

  // escape / UTF-8 state machine
  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (in_i.data_byte),
    .input_end_i (in_i.input_end),
    .grp_o       (grp)
  );

  // beats that cause no result leave the group register alone
  jsu_serialize u_serialize (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_wr_i      (in_accept && (grp.cnt != 3'd0)),
    .grp_i         (grp),
    .grp_free_o    (grp_free),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .out_byte_o    (res_o.out_byte),
    .byte_valid_o  (res_o.byte_valid),
    .last_o        (res_o.last),
    .string_done_o (res_o.string_done),
    .error_code_o  (res_o.error_code)
  );

endmodule

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the unescaper's result channel.
// ----------------------------------------------------------------------------
`include "json_string_unescape_macros.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       last_i,
  input logic       string_done_i,
  input logic [2:0] error_code_i
);
  import jsu_pkg::*;

  logic        status;
  logic [13:0] res_pay;

  assign status  = string_done_i || (error_code_i != ERR_NONE);
  assign res_pay = {out_byte_i, byte_valid_i, last_i, string_done_i, error_code_i};

  // stalled result holds
  `JSU_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_pay))

  // end-of-string result comes alone and carries no byte
  `JSU_ASSERT_IMP(a_status_alone, clk_i, rst_ni, res_valid_i && status, last_i && !byte_valid_i && (out_byte_i == 8'h00))

  // a result without a byte must end the string
  `JSU_ASSERT_IMP(a_nobyte_status, clk_i, rst_ni, res_valid_i && !byte_valid_i, status)

  // never done and failed at once
  `JSU_ASSERT_IMP(a_done_clean, clk_i, rst_ni, res_valid_i && string_done_i, error_code_i == ERR_NONE)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .out_byte_i    (res_o.out_byte),
  .byte_valid_i  (res_o.byte_valid),
  .last_i        (res_o.last),
  .string_done_i (res_o.string_done),
  .error_code_i  (res_o.error_code)
);

// ===== tb/jsu_unescape_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_unescape_checker
// Watches both channels of the string unescaper, decodes each accepted input
// beat on its own and compares every result beat against the oldest one due.
// ----------------------------------------------------------------------------
module jsu_unescape_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if.mon       in_i,
  jsu_out_if.mon      res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    ST_PLAIN,
    ST_CONT,
    ST_ESC,
    ST_HEX_HI,
    ST_WANT_BSL,
    ST_WANT_U,
    ST_HEX_LO
  } dec_st_e;

  typedef struct packed {
    logic [7:0] data;
    logic       data_vld;
    logic       last;
    logic       done;
    err_e       err;
  } res_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  dec_st_e     st;
  logic [15:0] acc;
  logic [2:0]  ndig;
  logic [9:0]  hi_surr;
  logic [1:0]  conts_left;

  res_t        due_q[$];    // decoded beats still owed by the block
  res_t        grp[$];      // results of the beat being decoded
  int unsigned mism_cnt = 0;
  int unsigned due_cnt  = 0;
  int unsigned res_idx  = 0;

  assign mismatch_cnt_o = mism_cnt;
  assign pending_o      = due_cnt;

  function automatic void clear_dec();
    st         = ST_PLAIN;
    acc        = '0;
    ndig       = '0;
    hi_surr    = '0;
    conts_left = '0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    res_t r;
    r = '{data: b, data_vld: 1'b1, last: 1'b0, done: 1'b0, err: ERR_NONE};
    grp = {grp, r};
  endfunction

  function automatic void put_end(logic d, err_e e);
    res_t r;
    r = '{data: 8'h00, data_vld: 1'b0, last: 1'b0, done: d, err: e};
    grp = {grp, r};
  endfunction

  function automatic void abort(err_e e);
    clear_dec();
    put_end(1'b0, e);
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void put_utf8(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  // decode one raw byte, queue whatever it owes
  function automatic void decode_beat(logic [7:0] b, logic fin);
    int nib;
    grp.delete();
    if (fin) begin
      abort(ERR_END);
    end else begin
      case (st)
        ST_CONT: begin
          if (b < 8'h80 || b > 8'hBF) begin
            abort(ERR_UTF8);
          end else begin
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0) st = ST_PLAIN;
            put_byte(b);
          end
        end
        ST_ESC: begin
          st = ST_PLAIN;
          case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: put_byte(b);
            "b": put_byte(8'h08);
            "f": put_byte(8'h0C);
            "n": put_byte(8'h0A);
            "r": put_byte(8'h0D);
            "t": put_byte(8'h09);
            CH_U: begin
              st   = ST_HEX_HI;
              acc  = '0;
              ndig = '0;
            end
            default: abort(ERR_ESCAPE);
          endcase
        end
        ST_HEX_HI, ST_HEX_LO: begin
          nib = hex_val(b);
          if (nib < 0) begin
            abort(ERR_HEX);
          end else begin
            acc  = {acc[11:0], 4'(nib)};
            ndig = ndig + 3'd1;
            if (ndig == 3'd4) begin
              ndig = '0;
              if (st == ST_HEX_HI) begin
                if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                  hi_surr = acc[9:0];
                  st      = ST_WANT_BSL;
                end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                  abort(ERR_SURR);
                end else begin
                  st = ST_PLAIN;
                  put_utf8({5'd0, acc});
                end
              end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                abort(ERR_SURR);
              end else begin
                st = ST_PLAIN;
                put_utf8({1'b0, hi_surr, acc[9:0]} + 21'h10000);
              end
            end
          end
        end
        ST_WANT_BSL: begin
          if (b != CH_BSL) abort(ERR_SURR);
          else st = ST_WANT_U;
        end
        ST_WANT_U: begin
          if (b != CH_U) begin
            abort(ERR_SURR);
          end else begin
            st   = ST_HEX_LO;
            acc  = '0;
            ndig = '0;
          end
        end
        default: begin
          st = ST_PLAIN;
          if (b == CH_QUOTE) begin
            clear_dec();
            put_end(1'b1, ERR_NONE);
          end else if (b == CH_BSL) begin
            st = ST_ESC;
          end else if (b < 8'h20) begin
            abort(ERR_CTRL);
          end else if (b <= 8'h7F) begin
            put_byte(b);
          end else if (b >= 8'hC0 && b <= 8'hF7) begin
            conts_left = (b <= 8'hDF) ? 2'd1 : (b <= 8'hEF) ? 2'd2 : 2'd3;
            st         = ST_CONT;
            put_byte(b);
          end else begin
            abort(ERR_UTF8);
          end
        end
      endcase
    end
    if (grp.size() > 0) grp[grp.size()-1].last = 1'b1;
    due_q = {due_q, grp};
  endfunction

  task automatic report_mismatch(input string msg);
    mism_cnt++;
    $display("jsu_chk: %s", msg);
  endtask

  task automatic check_result();
    res_t want;
    res_idx++;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("result %0d not owed: byte=%02h vld=%b done=%b err=%0d",
                                res_idx, res_i.out_byte, res_i.byte_valid,
                                res_i.string_done, res_i.error_code));
      return;
    end
    want = due_q.pop_front();
    if (res_i.out_byte !== want.data || res_i.byte_valid !== want.data_vld ||
        res_i.last !== want.last || res_i.string_done !== want.done ||
        res_i.error_code !== want.err)
      report_mismatch($sformatf(
        "result %0d: got %02h/%b/%b/%b/%0d want %02h/%b/%b/%b/%0d (byte/vld/last/done/err)",
        res_idx, res_i.out_byte, res_i.byte_valid, res_i.last, res_i.string_done,
        res_i.error_code, want.data, want.data_vld, want.last, want.done, want.err));
  endtask

  // result side first: nothing accepted at this edge can answer at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_dec();
      due_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (in_i.valid && in_i.ready) decode_beat(in_i.data_byte, in_i.input_end);
    end
    due_cnt <= due_q.size();
  end

endmodule

// ===== tb/tb_json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Drives raw string-body bytes into the unescaper and gives the verdict.
// A short directed run hits every non-hex error code, multi-byte passthrough,
// \u0000, a lone low surrogate and a mid-escape input end; a random run then
// mixes well-formed pieces (plain text, simple escapes, \u escapes, surrogate
// pairs, UTF-8 sequences, closing quotes) with noise and broken sequences.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;
  import jsu_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned NumItems   = 310;
  localparam int unsigned HoldCycles = 120;  // long sink stall, fills the block
  localparam int unsigned HoldAt     = 150;  // beat count that triggers it
  localparam int unsigned QuietFrom  = 90;   // stretch with no idling on
  localparam int unsigned QuietTo    = 170;  // either side

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] EscChars [8] = '{8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"};

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_if ();
  jsu_out_if res_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned items_sent = 0;
  logic        idle_on;
  logic        hold_req;

  json_string_unescape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  jsu_unescape_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Safety net: a run that has not finished by this time fails.
  initial begin
    #2_000_000;
    $display("[json_string_unescape] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One input beat. Random gaps precede it while idling is on; the beat then
  // stays up until the block takes it. Called right after a rising edge.
  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (idle_on && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.input_end <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_beat(q[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // a byte that is no hex digit: G..Z or anything below '0'
  function automatic logic [7:0] non_hex();
    if ($urandom_range(1)) return 8'($urandom_range(8'h5A, 8'h47));
    return 8'($urandom_range(8'h2F, 8'h00));
  endfunction

  // \uXXXX with mixed-case digits
  task automatic add_uescape(ref byte_q_t q, input logic [15:0] v);
    q = {q, CH_BSL};
    q = {q, CH_U};
    for (int i = 3; i >= 0; i--) q = {q, hex_char(v[i*4 +: 4], 1'($urandom_range(1)))};
  endtask

  function automatic logic [7:0] rand_lead(int unsigned conts);
    case (conts)
      1:       return 8'($urandom_range(8'hDF, 8'hC0));
      2:       return 8'($urandom_range(8'hEF, 8'hE0));
      default: return 8'($urandom_range(8'hF7, 8'hF0));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sink: random ready with one long hold-off, counted here
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 10) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source: reset, directed beats, random beats, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t     seg;
    int unsigned kind;
    int unsigned n;
    logic [15:0] v;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.input_end <= 1'b0;
    idle_on         <= 1'b1;
    hold_req        <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: top of ASCII, control byte, bad lead, widest UTF-8 sequence,
    // quote inside a sequence, bad escape, \u0000, lone low surrogate,
    // input end inside a \u escape, then a plain closing quote.
    send_bytes('{8'h41, 8'h7F, 8'h00, 8'hFF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hC3, CH_QUOTE, CH_BSL, "q",
                 CH_BSL, CH_U, "0", "0", "0", "0",
                 CH_BSL, CH_U, "D", "f", "F", "f",
                 CH_BSL, CH_U, "1"});
    send_beat(8'hA5, 1'b1);
    send_beat(CH_QUOTE, 1'b0);

    // Random: mostly well-formed pieces so the escape and surrogate states
    // get exercised, the rest noise and deliberately broken sequences.
    while (items_sent < NumItems) begin
      idle_on <= (items_sent < QuietFrom || items_sent >= QuietTo);
      if (items_sent >= HoldAt) hold_req <= 1'b1;
      seg  = {};
      kind = $urandom_range(99);
      if (kind < 22) begin
        // printable, not quote or backslash
        do v[7:0] = 8'($urandom_range(8'h7E, 8'h20));
        while (v[7:0] == CH_QUOTE || v[7:0] == CH_BSL);
        seg = {seg, v[7:0]};
      end else if (kind < 36) begin
        seg = {seg, CH_BSL};
        seg = {seg, EscChars[$urandom_range(7)]};
      end else if (kind < 50) begin
        // \u in each UTF-8 length class, surrogates left out
        case ($urandom_range(3))
          0:       v = 16'($urandom_range(16'h007F));
          1:       v = 16'($urandom_range(16'h07FF, 16'h0080));
          2:       v = 16'($urandom_range(16'hD7FF, 16'h0800));
          default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
        endcase
        add_uescape(seg, v);
      end else if (kind < 60) begin
        add_uescape(seg, {6'b110110, 10'($urandom)});
        add_uescape(seg, {6'b110111, 10'($urandom)});
      end else if (kind < 70) begin
        n = $urandom_range(3, 1);
        seg = {seg, rand_lead(n)};
        repeat (n) seg = {seg, 8'($urandom_range(8'hBF, 8'h80))};
      end else if (kind < 77) begin
        seg = {seg, CH_QUOTE};
      end else if (kind < 81) begin
        send_beat(8'($urandom_range(255)), 1'b1);
      end else if (kind < 89) begin
        seg = {seg, 8'($urandom_range(255))};
      end else begin
        case ($urandom_range(5))
          0: begin  // high surrogate, then anything
            add_uescape(seg, {6'b110110, 10'($urandom)});
            seg = {seg, 8'($urandom_range(255))};
          end
          1: begin  // non-hex digit part way into \u
            seg = {seg, CH_BSL};
            seg = {seg, CH_U};
            repeat ($urandom_range(3)) seg = {seg, hex_char(4'($urandom), 1'($urandom))};
            seg = {seg, non_hex()};
          end
          2: begin  // second half not a low surrogate
            add_uescape(seg, {6'b110110, 10'($urandom)});
            if ($urandom_range(1)) add_uescape(seg, 16'($urandom_range(16'hDBFF)));
            else add_uescape(seg, 16'($urandom_range(16'hFFFF, 16'hE000)));
          end
          3: begin  // backslash and a random byte
            seg = {seg, CH_BSL};
            seg = {seg, 8'($urandom_range(255))};
          end
          4: begin  // lone low surrogate
            add_uescape(seg, {6'b110111, 10'($urandom)});
          end
          default: begin  // sequence cut by a non-continuation byte
            seg = {seg, rand_lead($urandom_range(3, 1))};
            if ($urandom_range(1)) seg = {seg, 8'($urandom_range(8'h7F))};
            else seg = {seg, 8'($urandom_range(8'hFF, 8'hC0))};
          end
        endcase
      end
      send_bytes(seg);
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    // drain, then wait out anything stray
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[json_string_unescape] OK");
    end else begin
      $display("[json_string_unescape] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_ifs.sv
rtl/jsu_decode.sv
rtl/jsu_serialize.sv
rtl/json_string_unescape.sv
rtl/jsu_checker.sv
tb/jsu_unescape_checker.sv
tb/tb_json_string_unescape.sv
